// ===== hdl/volume_reorient_address_gen_unit_assert.svh =====
// Assertion macros for the volume reorient address generator.
// Each use stands on a line of its own, without a trailing semicolon.
`ifndef VOLUME_REORIENT_ADDRESS_GEN_UNIT_ASSERT_SVH
`define VOLUME_REORIENT_ADDRESS_GEN_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Concurrent assertion on an explicit clock and active-low reset
`define VRAG_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset
`define VRAG_ASSERT(label, prop, msg) \
  `VRAG_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`else

`define VRAG_ASSERT_CLK(label, clk, rst_n, prop, msg)

`define VRAG_ASSERT(label, prop, msg)

`endif

`endif

// ===== hdl/vrag_pkg.sv =====
`default_nettype none

package vrag_pkg;

  // Fixed field widths
  localparam int unsigned MODE_W     = 4;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned ORIENT_W   = 2;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  // Parameter defaults
  localparam int unsigned MAX_DIM_DEFAULT    = 256;
  localparam int unsigned VOXEL_BITS_DEFAULT = 16;
  localparam int unsigned QUEUE_DEPTH        = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ORIENT = 3'd4;

  // Reorientation modes
  localparam logic [MODE_W-1:0] MODE_KEEP     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SWAP_YZ  = 4'd1;
  localparam logic [MODE_W-1:0] MODE_SWAP_XY  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_YZX      = 4'd3;
  localparam logic [MODE_W-1:0] MODE_ZXY      = 4'd4;
  localparam logic [MODE_W-1:0] MODE_SWAP_XZ  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_ROT_X90  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_ROT_X180 = 4'd7;
  localparam logic [MODE_W-1:0] MODE_ROT_X270 = 4'd8;
  localparam logic [MODE_W-1:0] MODE_ROT_Y90  = 4'd9;
  localparam logic [MODE_W-1:0] MODE_ROT_Y180 = 4'd10;
  localparam logic [MODE_W-1:0] MODE_ROT_Y270 = 4'd11;
  localparam logic [MODE_W-1:0] MODE_ROT_Z90  = 4'd12;
  localparam logic [MODE_W-1:0] MODE_ROT_Z180 = 4'd13;
  localparam logic [MODE_W-1:0] MODE_ROT_Z270 = 4'd14;

  // Orientation labels
  localparam logic [ORIENT_W-1:0] ORIENT_AXIAL    = 2'd0;
  localparam logic [ORIENT_W-1:0] ORIENT_SAGITTAL = 2'd1;
  localparam logic [ORIENT_W-1:0] ORIENT_CORONAL  = 2'd2;
  localparam logic [ORIENT_W-1:0] ORIENT_OTHER    = 2'd3;

  // Register reset values
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== hdl/vrag_fifo.sv =====
`default_nettype none

module vrag_fifo import vrag_pkg::*; #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             rd_i,
  output logic      [WIDTH-1:0] rdata_o,
  output q_status_t             status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({wr_i, rd_i})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o        = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// ===== hdl/vrag_front.sv =====
`default_nettype none

module vrag_front import vrag_pkg::*; #(
  parameter int unsigned MAX_DIM    = MAX_DIM_DEFAULT,
  parameter int unsigned VOXEL_BITS = VOXEL_BITS_DEFAULT,
  localparam int unsigned CW  = $clog2(MAX_DIM),
  localparam int unsigned EW  = $clog2(MAX_DIM + 1),
  localparam int unsigned PLF = $clog2(MAX_DIM * MAX_DIM + 1),
  localparam int unsigned PLW = (PLF > ADDR_W) ? ADDR_W : PLF,
  localparam int unsigned IW  = VOXEL_BITS + 3 * CW + 1 + ORIENT_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  push_i,
  input  wire logic [VOXEL_BITS-1:0] voxel_value_i,
  input  wire logic                  q_full_i,
  output logic                       q_wr_o,
  output logic      [IW-1:0]         q_wdata_o,
  output logic      [EW-1:0]         ox_o,
  output logic      [PLW-1:0]        plane_o
);

  // Clamp an extent register to 1..MAX_DIM
  function automatic logic [EW-1:0] eff_extent(input logic [SIZE_W-1:0] sz);
    logic [EW-1:0] r;
    if (sz == '0) begin
      r = EW'(1);
    end else if (32'(sz) > MAX_DIM) begin
      r = EW'(MAX_DIM);
    end else begin
      r = EW'(sz);
    end
    return r;
  endfunction

  // Orientation label of the output volume
  function automatic logic [ORIENT_W-1:0] dest_orient(input logic [MODE_W-1:0]   m,
                                                      input logic [ORIENT_W-1:0] o);
    logic [ORIENT_W-1:0] r;
    r = o;
    if (o != ORIENT_OTHER) begin
      case (m)
        MODE_SWAP_YZ: r = (o == ORIENT_AXIAL) ? ORIENT_SAGITTAL : ORIENT_AXIAL;
        MODE_YZX,
        MODE_SWAP_XZ: r = (o == ORIENT_SAGITTAL) ? ORIENT_CORONAL : ORIENT_SAGITTAL;
        MODE_ZXY:     r = (o == ORIENT_AXIAL) ? ORIENT_CORONAL : ORIENT_AXIAL;
        default:      r = o;
      endcase
    end
    return r;
  endfunction

  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [SIZE_W-1:0]   size_x_q, size_x_d;
  logic [SIZE_W-1:0]   size_y_q, size_y_d;
  logic [SIZE_W-1:0]   size_z_q, size_z_d;
  logic [ORIENT_W-1:0] orient_q, orient_d;
  logic [CW-1:0]       cnt_x_q, cnt_x_d;
  logic [CW-1:0]       cnt_y_q, cnt_y_d;
  logic [CW-1:0]       cnt_z_q, cnt_z_d;
  logic [PLW-1:0]      plane_q;
  logic                cfg_hit;

  logic [EW-1:0]   ext_x, ext_y, ext_z;
  logic [EW-1:0]   ox, oy;
  logic [2*EW-1:0] plane_full;
  logic [EW-1:0]   rev_x, rev_y, rev_z;
  logic [CW-1:0]   dx, dy, dz;
  logic            lx, ly, lz;

  // Effective extents and output plane geometry
  assign ext_x = eff_extent(size_x_q);
  assign ext_y = eff_extent(size_y_q);
  assign ext_z = eff_extent(size_z_q);

  always_comb begin
    case (mode_q)
      MODE_SWAP_YZ, MODE_ROT_X90, MODE_ROT_X270: begin
        ox = ext_x;
        oy = ext_z;
      end
      MODE_SWAP_XY, MODE_ROT_Z90, MODE_ROT_Z270: begin
        ox = ext_y;
        oy = ext_x;
      end
      MODE_YZX: begin
        ox = ext_y;
        oy = ext_z;
      end
      MODE_ZXY: begin
        ox = ext_z;
        oy = ext_x;
      end
      MODE_SWAP_XZ, MODE_ROT_Y90, MODE_ROT_Y270: begin
        ox = ext_z;
        oy = ext_y;
      end
      default: begin
        ox = ext_x;
        oy = ext_y;
      end
    endcase
  end

  assign plane_full = ox * oy;

  // Plane size is registered and follows the config registers in the next cycle
  always_ff @(posedge clk_i) begin
    plane_q <= PLW'(plane_full);
  end

  assign ox_o    = ox;
  assign plane_o = plane_q;

  // Mirrored source coordinates
  assign rev_x = ext_x - EW'(1) - EW'(cnt_x_q);
  assign rev_y = ext_y - EW'(1) - EW'(cnt_y_q);
  assign rev_z = ext_z - EW'(1) - EW'(cnt_z_q);

  // Destination coordinate mapping
  always_comb begin
    case (mode_q)
      MODE_SWAP_YZ:  begin dx = cnt_x_q;     dy = cnt_z_q;     dz = cnt_y_q;     end
      MODE_SWAP_XY:  begin dx = cnt_y_q;     dy = cnt_x_q;     dz = cnt_z_q;     end
      MODE_YZX:      begin dx = cnt_y_q;     dy = cnt_z_q;     dz = cnt_x_q;     end
      MODE_ZXY:      begin dx = cnt_z_q;     dy = cnt_x_q;     dz = cnt_y_q;     end
      MODE_SWAP_XZ:  begin dx = cnt_z_q;     dy = cnt_y_q;     dz = cnt_x_q;     end
      MODE_ROT_X90:  begin dx = cnt_x_q;     dy = CW'(rev_z);  dz = cnt_y_q;     end
      MODE_ROT_X180: begin dx = cnt_x_q;     dy = CW'(rev_y);  dz = CW'(rev_z);  end
      MODE_ROT_X270: begin dx = cnt_x_q;     dy = cnt_z_q;     dz = CW'(rev_y);  end
      MODE_ROT_Y90:  begin dx = CW'(rev_z);  dy = cnt_y_q;     dz = cnt_x_q;     end
      MODE_ROT_Y180: begin dx = CW'(rev_x);  dy = cnt_y_q;     dz = CW'(rev_z);  end
      MODE_ROT_Y270: begin dx = cnt_z_q;     dy = cnt_y_q;     dz = CW'(rev_x);  end
      MODE_ROT_Z90:  begin dx = CW'(rev_y);  dy = cnt_x_q;     dz = cnt_z_q;     end
      MODE_ROT_Z180: begin dx = CW'(rev_x);  dy = CW'(rev_y);  dz = cnt_z_q;     end
      MODE_ROT_Z270: begin dx = cnt_y_q;     dy = CW'(rev_x);  dz = cnt_z_q;     end
      default:       begin dx = cnt_x_q;     dy = cnt_y_q;     dz = cnt_z_q;     end
    endcase
  end

  // End-of-row, end-of-plane and end-of-volume flags
  assign lx = (EW'(cnt_x_q) >= ext_x - EW'(1));
  assign ly = (EW'(cnt_y_q) >= ext_y - EW'(1));
  assign lz = (EW'(cnt_z_q) >= ext_z - EW'(1));

  assign q_wr_o    = push_i && !q_full_i;
  assign q_wdata_o = {voxel_value_i, dx, dy, dz, (lx && ly && lz),
                      dest_orient(mode_q, orient_q)};

  // Config writes and raster counters
  always_comb begin
    mode_d   = mode_q;
    size_x_d = size_x_q;
    size_y_d = size_y_q;
    size_z_d = size_z_q;
    orient_d = orient_q;
    cnt_x_d  = cnt_x_q;
    cnt_y_d  = cnt_y_q;
    cnt_z_d  = cnt_z_q;
    cfg_hit  = 1'b0;
    if (cfg_we_i) begin
      cfg_hit = 1'b1;
      case (cfg_idx_i)
        REG_MODE:       mode_d   = cfg_data_i[MODE_W-1:0];
        REG_SIZE_X:     size_x_d = cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Y:     size_y_d = cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Z:     size_z_d = cfg_data_i[SIZE_W-1:0];
        REG_SRC_ORIENT: orient_d = cfg_data_i[ORIENT_W-1:0];
        default:        cfg_hit  = 1'b0;
      endcase
    end
    if (cfg_hit) begin
      cnt_x_d = '0;
      cnt_y_d = '0;
      cnt_z_d = '0;
    end else if (q_wr_o) begin
      if (!lx) begin
        cnt_x_d = cnt_x_q + CW'(1);
      end else begin
        cnt_x_d = '0;
        if (!ly) begin
          cnt_y_d = cnt_y_q + CW'(1);
        end else begin
          cnt_y_d = '0;
          cnt_z_d = lz ? '0 : cnt_z_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_KEEP;
      size_x_q <= SIZE_RESET;
      size_y_q <= SIZE_RESET;
      size_z_q <= SIZE_RESET;
      orient_q <= ORIENT_AXIAL;
      cnt_x_q  <= '0;
      cnt_y_q  <= '0;
      cnt_z_q  <= '0;
    end else begin
      mode_q   <= mode_d;
      size_x_q <= size_x_d;
      size_y_q <= size_y_d;
      size_z_q <= size_z_d;
      orient_q <= orient_d;
      cnt_x_q  <= cnt_x_d;
      cnt_y_q  <= cnt_y_d;
      cnt_z_q  <= cnt_z_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vrag_back.sv =====
`default_nettype none

module vrag_back import vrag_pkg::*; #(
  parameter int unsigned MAX_DIM    = MAX_DIM_DEFAULT,
  parameter int unsigned VOXEL_BITS = VOXEL_BITS_DEFAULT,
  localparam int unsigned CW  = $clog2(MAX_DIM),
  localparam int unsigned EW  = $clog2(MAX_DIM + 1),
  localparam int unsigned PLF = $clog2(MAX_DIM * MAX_DIM + 1),
  localparam int unsigned PLW = (PLF > ADDR_W) ? ADDR_W : PLF,
  localparam int unsigned IW  = VOXEL_BITS + 3 * CW + 1 + ORIENT_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  q_status_t                  q_status_i,
  input  wire logic [IW-1:0]         q_rdata_i,
  output logic                       q_pop_o,
  input  wire logic [EW-1:0]         ox_i,
  input  wire logic [PLW-1:0]        plane_i,
  input  wire logic                  pop_i,
  output logic                       empty_o,
  output logic      [VOXEL_BITS-1:0] voxel_out_o,
  output logic      [COORD_W-1:0]    dest_x_o,
  output logic      [COORD_W-1:0]    dest_y_o,
  output logic      [COORD_W-1:0]    dest_z_o,
  output logic      [ADDR_W-1:0]     dest_address_o,
  output logic                       last_voxel_o,
  output logic      [ORIENT_W-1:0]   result_orientation_o
);

  // Queue entry fields
  logic [VOXEL_BITS-1:0] in_voxel;
  logic [CW-1:0]         in_dx, in_dy, in_dz;
  logic                  in_last;
  logic [ORIENT_W-1:0]   in_orient;

  assign {in_voxel, in_dx, in_dy, in_dz, in_last, in_orient} = q_rdata_i;

  logic [CW+EW-1:0]  mul_y;
  logic [CW+PLW-1:0] mul_z;

  // Multiply stage
  logic                  s1_valid_q, s1_valid_d;
  logic [VOXEL_BITS-1:0] s1_voxel_q;
  logic [CW-1:0]         s1_dx_q, s1_dy_q, s1_dz_q;
  logic [ADDR_W-1:0]     s1_py_q, s1_pz_q;
  logic                  s1_last_q;
  logic [ORIENT_W-1:0]   s1_orient_q;

  // Result stage
  logic                  s2_valid_q, s2_valid_d;
  logic [VOXEL_BITS-1:0] s2_voxel_q;
  logic [COORD_W-1:0]    s2_dx_q, s2_dy_q, s2_dz_q;
  logic [ADDR_W-1:0]     s2_addr_q;
  logic                  s2_last_q;
  logic [ORIENT_W-1:0]   s2_orient_q;

  logic s1_load, s2_adv;

  // Pipeline flow control
  assign s2_adv     = s1_valid_q && (!s2_valid_q || pop_i);
  assign s1_load    = !q_status_i.empty && (!s1_valid_q || s2_adv);
  assign q_pop_o    = s1_load;
  assign s1_valid_d = s1_load || (s1_valid_q && !s2_adv);
  assign s2_valid_d = s2_adv || (s2_valid_q && !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Row and plane offsets
  assign mul_y = in_dy * ox_i;
  assign mul_z = in_dz * plane_i;

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_voxel_q  <= in_voxel;
      s1_dx_q     <= in_dx;
      s1_dy_q     <= in_dy;
      s1_dz_q     <= in_dz;
      s1_py_q     <= ADDR_W'(mul_y);
      s1_pz_q     <= ADDR_W'(mul_z);
      s1_last_q   <= in_last;
      s1_orient_q <= in_orient;
    end
  end

  // Final address sum, wraps at the address width
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s2_voxel_q  <= s1_voxel_q;
      s2_dx_q     <= COORD_W'(s1_dx_q);
      s2_dy_q     <= COORD_W'(s1_dy_q);
      s2_dz_q     <= COORD_W'(s1_dz_q);
      s2_addr_q   <= ADDR_W'(s1_dx_q) + s1_py_q + s1_pz_q;
      s2_last_q   <= s1_last_q;
      s2_orient_q <= s1_orient_q;
    end
  end

  assign empty_o              = !s2_valid_q;
  assign voxel_out_o          = s2_voxel_q;
  assign dest_x_o             = s2_dx_q;
  assign dest_y_o             = s2_dy_q;
  assign dest_z_o             = s2_dz_q;
  assign dest_address_o       = s2_addr_q;
  assign last_voxel_o         = s2_last_q;
  assign result_orientation_o = s2_orient_q;

endmodule

`default_nettype wire

// ===== hdl/volume_reorient_address_gen_unit.sv =====
// Volume reorientation address generator.
// Input queue side: voxels arrive in raster order (x fastest, then y, then z)
// on voxel_value_i and are taken when push is high and full is low. The block
// counts the source x, y, z itself.
// Result queue side: while empty is low the oldest result is on the output
// ports (voxel, destination coordinates, linear write address, last-voxel
// flag, output orientation label); pop high with empty low takes it.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i (mode,
// size_x, size_y, size_z, source_orientation); any such write restarts the
// counters at the first voxel. Write only while no transaction is in flight.
// Path: a voxel accepted on the input passes the queue write, the multiply
// stage and the address-sum stage before it can be popped.
// Throughput: one voxel per cycle while the receiver pops; the front counter/mapper
// and the back multiply/add pipeline each handle one transaction per clock.
// Reset: mode keep, extents 256, orientation axial, counters zero, queue and
// pipeline empty. No clearing pass is needed.
// Stall: when pop stays low the result holds; the back pipeline and the
// two-entry queue fill, then full rises until the receiver pops again.
`default_nettype none
`include "volume_reorient_address_gen_unit_assert.svh"

module volume_reorient_address_gen_unit import vrag_pkg::*; #(
  parameter int unsigned MAX_DIM    = MAX_DIM_DEFAULT,
  parameter int unsigned VOXEL_BITS = VOXEL_BITS_DEFAULT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [VOXEL_BITS-1:0] voxel_value_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [VOXEL_BITS-1:0] voxel_out_o,
  output logic      [COORD_W-1:0]    dest_x_o,
  output logic      [COORD_W-1:0]    dest_y_o,
  output logic      [COORD_W-1:0]    dest_z_o,
  output logic      [ADDR_W-1:0]     dest_address_o,
  output logic                       last_voxel_o,
  output logic      [ORIENT_W-1:0]   result_orientation_o
);

  localparam int unsigned CW  = $clog2(MAX_DIM);
  localparam int unsigned EW  = $clog2(MAX_DIM + 1);
  localparam int unsigned PLF = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int unsigned PLW = (PLF > ADDR_W) ? ADDR_W : PLF;
  localparam int unsigned IW  = VOXEL_BITS + 3 * CW + 1 + ORIENT_W;

  logic           q_wr;
  logic [IW-1:0]  q_wdata;
  logic           q_pop;
  logic [IW-1:0]  q_rdata;
  q_status_t      q_status;
  logic [EW-1:0]  ox;
  logic [PLW-1:0] plane;

  // Front: config, raster counters, coordinate mapping
  vrag_front #(
    .MAX_DIM    (MAX_DIM),
    .VOXEL_BITS (VOXEL_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push_i        (push),
    .voxel_value_i (voxel_value_i),
    .q_full_i      (q_status.full),
    .q_wr_o        (q_wr),
    .q_wdata_o     (q_wdata),
    .ox_o          (ox),
    .plane_o       (plane)
  );

  // Decoupling queue
  vrag_fifo #(
    .WIDTH (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wdata_i  (q_wdata),
    .rd_i     (q_pop),
    .rdata_o  (q_rdata),
    .status_o (q_status)
  );

  // Back: address arithmetic and result register
  vrag_back #(
    .MAX_DIM    (MAX_DIM),
    .VOXEL_BITS (VOXEL_BITS)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .q_status_i           (q_status),
    .q_rdata_i            (q_rdata),
    .q_pop_o              (q_pop),
    .ox_i                 (ox),
    .plane_i              (plane),
    .pop_i                (pop),
    .empty_o              (empty),
    .voxel_out_o          (voxel_out_o),
    .dest_x_o             (dest_x_o),
    .dest_y_o             (dest_y_o),
    .dest_z_o             (dest_z_o),
    .dest_address_o       (dest_address_o),
    .last_voxel_o         (last_voxel_o),
    .result_orientation_o (result_orientation_o)
  );

  assign full = q_status.full;

  // Queue integrity between front and back
  `VRAG_ASSERT(a_no_wr_when_full, q_status.full |-> !q_wr, "queue written while full")
  `VRAG_ASSERT(a_no_rd_when_empty, q_status.empty |-> !q_pop, "queue read while empty")
  `VRAG_ASSERT(a_wr_fills, q_wr && q_status.empty |=> !q_status.empty, "queue write lost")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
  import vrag_pkg::*;

  localparam int unsigned VB            = VOXEL_BITS_DEFAULT;
  localparam int unsigned RANDOM_VOXELS = 1750;
  localparam int unsigned MAX_EXTENT    = MAX_DIM_DEFAULT;

  // One reoriented voxel as it leaves the block
  typedef struct packed {
    logic [VB-1:0]       voxel;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic [ADDR_W-1:0]   addr;
    logic                last_flag;
    logic [ORIENT_W-1:0] orient;
  } dest_voxel_t;

  // Tracks the raster position and mapping, and holds destinations not yet popped
  class voxel_mapper;
    logic [MODE_W-1:0]   mode_q;
    logic [SIZE_W-1:0]   size_x_q;
    logic [SIZE_W-1:0]   size_y_q;
    logic [SIZE_W-1:0]   size_z_q;
    logic [ORIENT_W-1:0] orient_q;
    int unsigned         col, row, slice, plane_area;
    dest_voxel_t         pending_dests[$];
    int unsigned         errors;

    function new();
      mode_q   = MODE_KEEP;
      size_x_q = SIZE_RESET;
      size_y_q = SIZE_RESET;
      size_z_q = SIZE_RESET;
      orient_q = ORIENT_AXIAL;
      errors   = 0;
      restart();
    endfunction

    // Zero acts as one, anything past the maximum acts as the maximum
    function int unsigned extent(logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_EXTENT) return MAX_EXTENT;
      return v;
    endfunction

    // Output x/y extents for the current mode
    function void out_dims(output int unsigned ox, output int unsigned oy);
      int unsigned ex, ey, ez;
      ex = extent(size_x_q);
      ey = extent(size_y_q);
      ez = extent(size_z_q);
      case (mode_q)
        MODE_SWAP_YZ, MODE_ROT_X90, MODE_ROT_X270: begin ox = ex; oy = ez; end
        MODE_SWAP_XY, MODE_ROT_Z90, MODE_ROT_Z270: begin ox = ey; oy = ex; end
        MODE_YZX:                                  begin ox = ey; oy = ez; end
        MODE_ZXY:                                  begin ox = ez; oy = ex; end
        MODE_SWAP_XZ, MODE_ROT_Y90, MODE_ROT_Y270: begin ox = ez; oy = ey; end
        default:                                   begin ox = ex; oy = ey; end
      endcase
    endfunction

    function void restart();
      int unsigned ox, oy;
      col   = 0;
      row   = 0;
      slice = 0;
      out_dims(ox, oy);
      plane_area = ox * oy;
    endfunction

    function logic [ORIENT_W-1:0] out_orient();
      if (orient_q == ORIENT_OTHER) return orient_q;
      case (mode_q)
        MODE_SWAP_YZ: return (orient_q == ORIENT_AXIAL) ? ORIENT_SAGITTAL : ORIENT_AXIAL;
        MODE_YZX, MODE_SWAP_XZ:
          return (orient_q == ORIENT_SAGITTAL) ? ORIENT_CORONAL : ORIENT_SAGITTAL;
        MODE_ZXY:     return (orient_q == ORIENT_AXIAL) ? ORIENT_CORONAL : ORIENT_AXIAL;
        default:      return orient_q;
      endcase
    endfunction

    // Register write; an unknown index leaves everything alone
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE:       mode_q   = data[MODE_W-1:0];
        REG_SIZE_X:     size_x_q = data[SIZE_W-1:0];
        REG_SIZE_Y:     size_y_q = data[SIZE_W-1:0];
        REG_SIZE_Z:     size_z_q = data[SIZE_W-1:0];
        REG_SRC_ORIENT: orient_q = data[ORIENT_W-1:0];
        default:        return;
      endcase
      restart();
    endfunction

    // Map one accepted voxel and advance the raster counters
    function void take_voxel(logic [VB-1:0] v);
      int unsigned ex, ey, ez, dx, dy, dz, ox, oy, addr;
      bit          lx, ly, lz;
      dest_voxel_t r;
      ex = extent(size_x_q);
      ey = extent(size_y_q);
      ez = extent(size_z_q);
      dx = col;
      dy = row;
      dz = slice;
      case (mode_q)
        MODE_SWAP_YZ:  begin dx = col;            dy = slice;          dz = row;            end
        MODE_SWAP_XY:  begin dx = row;            dy = col;            dz = slice;          end
        MODE_YZX:      begin dx = row;            dy = slice;          dz = col;            end
        MODE_ZXY:      begin dx = slice;          dy = col;            dz = row;            end
        MODE_SWAP_XZ:  begin dx = slice;          dy = row;            dz = col;            end
        MODE_ROT_X90:  begin dx = col;            dy = ez - 1 - slice; dz = row;            end
        MODE_ROT_X180: begin dx = col;            dy = ey - 1 - row;   dz = ez - 1 - slice; end
        MODE_ROT_X270: begin dx = col;            dy = slice;          dz = ey - 1 - row;   end
        MODE_ROT_Y90:  begin dx = ez - 1 - slice; dy = row;            dz = col;            end
        MODE_ROT_Y180: begin dx = ex - 1 - col;   dy = row;            dz = ez - 1 - slice; end
        MODE_ROT_Y270: begin dx = slice;          dy = row;            dz = ex - 1 - col;   end
        MODE_ROT_Z90:  begin dx = ey - 1 - row;   dy = col;            dz = slice;          end
        MODE_ROT_Z180: begin dx = ex - 1 - col;   dy = ey - 1 - row;   dz = slice;          end
        MODE_ROT_Z270: begin dx = row;            dy = ex - 1 - col;   dz = slice;          end
        default: ;
      endcase
      out_dims(ox, oy);
      addr = dx + dy * ox + dz * plane_area;
      lx = (col >= ex - 1);
      ly = (row >= ey - 1);
      lz = (slice >= ez - 1);

      r.voxel     = v;
      r.x         = dx[COORD_W-1:0];
      r.y         = dy[COORD_W-1:0];
      r.z         = dz[COORD_W-1:0];
      r.addr      = addr[ADDR_W-1:0];
      r.last_flag = lx && ly && lz;
      r.orient    = out_orient();
      pending_dests.push_back(r);

      if (!lx) begin
        col++;
      end else begin
        col = 0;
        if (!ly) begin
          row++;
        end else begin
          row   = 0;
          slice = lz ? 0 : slice + 1;
        end
      end
    endfunction

    task flag(string what);
      errors++;
      if (errors <= 30) $display("ERROR: %s", what);
    endtask

    // Compare a popped transaction with the oldest destination waiting
    task match_result(dest_voxel_t got);
      dest_voxel_t want;
      if (pending_dests.size() == 0) begin
        flag($sformatf("result with nothing pending: addr %0h", got.addr));
        return;
      end
      want = pending_dests.pop_front();
      if (got.voxel !== want.voxel)
        flag($sformatf("voxel got %0h want %0h", got.voxel, want.voxel));
      if (got.x !== want.x) flag($sformatf("dest_x got %0d want %0d", got.x, want.x));
      if (got.y !== want.y) flag($sformatf("dest_y got %0d want %0d", got.y, want.y));
      if (got.z !== want.z) flag($sformatf("dest_z got %0d want %0d", got.z, want.z));
      if (got.addr !== want.addr)
        flag($sformatf("address got %0h want %0h", got.addr, want.addr));
      if (got.last_flag !== want.last_flag)
        flag($sformatf("last_voxel got %0b want %0b", got.last_flag, want.last_flag));
      if (got.orient !== want.orient)
        flag($sformatf("orientation got %0d want %0d", got.orient, want.orient));
    endtask

    function int unsigned pending();
      return pending_dests.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  push;
  logic                  full;
  logic [VB-1:0]         voxel_value_i;
  logic                  empty;
  logic                  pop;
  logic [VB-1:0]         voxel_out_o;
  logic [COORD_W-1:0]    dest_x_o;
  logic [COORD_W-1:0]    dest_y_o;
  logic [COORD_W-1:0]    dest_z_o;
  logic [ADDR_W-1:0]     dest_address_o;
  logic                  last_voxel_o;
  logic [ORIENT_W-1:0]   result_orientation_o;

  voxel_mapper mapper = new();
  dest_voxel_t seen;
  int          tx_idle_pct  = 35;
  int          rx_idle_pct  = 55;
  int          rx_hold_left = 0;

  volume_reorient_address_gen_unit dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .push                 (push),
    .full                 (full),
    .voxel_value_i        (voxel_value_i),
    .empty                (empty),
    .pop                  (pop),
    .voxel_out_o          (voxel_out_o),
    .dest_x_o             (dest_x_o),
    .dest_y_o             (dest_y_o),
    .dest_z_o             (dest_z_o),
    .dest_address_o       (dest_address_o),
    .last_voxel_o         (last_voxel_o),
    .result_orientation_o (result_orientation_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Monitor: both handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) mapper.take_voxel(voxel_value_i);
      if (pop && !empty) begin
        seen.voxel     = voxel_out_o;
        seen.x         = dest_x_o;
        seen.y         = dest_y_o;
        seen.z         = dest_z_o;
        seen.addr      = dest_address_o;
        seen.last_flag = last_voxel_o;
        seen.orient    = result_orientation_o;
        mapper.match_result(seen);
      end
    end
  end

  // Receiver: random pop, or a long hold-off when requested
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        pop <= 1'b0;
        rx_hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Leaves cfg_we_i high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    mapper.write_reg(idx, data);
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] m, input logic [CFG_DATA_W-1:0] sx,
                              input logic [CFG_DATA_W-1:0] sy, input logic [CFG_DATA_W-1:0] sz,
                              input logic [CFG_DATA_W-1:0] o);
    write_reg(REG_MODE, m);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_SRC_ORIENT, o);
    cfg_we_i <= 1'b0;
  endtask

  // Write to an index past the register list
  task automatic write_unused();
    write_reg(REG_SRC_ORIENT + CFG_IDX_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_voxel(input logic [VB-1:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    voxel_value_i <= v;
    do @(posedge clk_i); while (full);
  endtask

  // Stop offering and wait for every pending destination to come out
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (mapper.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_voxel(VB'($urandom));
    drain();
  endtask

  // Stimulus
  initial begin
    int unsigned random_done;
    int unsigned count, vol, kind, axis;
    bit          hold_done;
    logic [CFG_DATA_W-1:0] sz[3];
    logic [CFG_DATA_W-1:0] m, o;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_MODE;
    cfg_data_i    = '0;
    push          = 1'b0;
    voxel_value_i = '0;
    random_done   = 0;
    hold_done     = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: keep mode over the full 256 cube
    send_voxel('0);
    send_voxel('1);
    send_voxel(16'hAAAA);
    send_voxel(16'h5555);
    drain();

    // Unused mode 15 acts as keep; upper data bits of the mode write are ignored
    write_config(9'h1FF, 9'd2, 9'd1, 9'd2, CFG_DATA_W'(ORIENT_OTHER));
    send_random(4);

    // Extents out of range: zero acts as one, above the maximum saturates
    write_config(CFG_DATA_W'(MODE_ROT_Z180), 9'd0, 9'd300, 9'd511,
                 CFG_DATA_W'(ORIENT_CORONAL));
    send_random(3);

    // A write past the register list must not restart the raster counters
    write_config(CFG_DATA_W'(MODE_ROT_X90), 9'd2, 9'd2, 9'd2, CFG_DATA_W'(ORIENT_SAGITTAL));
    send_random(3);
    write_unused();
    send_random(5);

    // Random volumes
    while (random_done < RANDOM_VOXELS) begin
      if (random_done < RANDOM_VOXELS / 3) begin
        tx_idle_pct = 35;
        rx_idle_pct = 55;
      end else if (random_done < 2 * RANDOM_VOXELS / 3) begin
        tx_idle_pct = 55;
        rx_idle_pct = 35;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      if ($urandom_range(4) == 0) begin
        // Keep the configuration and carry on from the current raster position
        count = $urandom_range(1, 40);
      end else begin
        m    = CFG_DATA_W'($urandom_range(15));
        o    = CFG_DATA_W'($urandom_range(3));
        kind = $urandom_range(7);
        if (kind == 0) begin
          // One long axis, to reach coordinate 255 on it
          axis = $urandom_range(2);
          foreach (sz[i]) sz[i] = CFG_DATA_W'($urandom_range(1));
          sz[axis] = $urandom_range(1) ? CFG_DATA_W'(SIZE_RESET)
                                       : CFG_DATA_W'($urandom_range(257, 511));
          count = MAX_EXTENT;
        end else if (kind == 1) begin
          // A flat slab
          foreach (sz[i]) sz[i] = CFG_DATA_W'($urandom_range(1, 16));
          sz[$urandom_range(2)] = CFG_DATA_W'($urandom_range(1));
          count = mapper.extent(sz[0]) * mapper.extent(sz[1]) * mapper.extent(sz[2]);
        end else begin
          // Small volumes, whole, repeated or cut short
          foreach (sz[i]) sz[i] = ($urandom_range(9) == 0) ? '0
                                                           : CFG_DATA_W'($urandom_range(1, 5));
          vol = mapper.extent(sz[0]) * mapper.extent(sz[1]) * mapper.extent(sz[2]);
          count = ($urandom_range(3) == 0) ? $urandom_range(1, 2 * vol)
                                           : vol * $urandom_range(1, 2);
        end
        if ($urandom_range(3) == 0) write_unused();
        write_config(m, sz[0], sz[1], sz[2], o);
      end

      // Once, hold the receiver off long enough for the block to fill and stall
      if (rx_idle_pct == 0 && !hold_done) begin
        if (count < 16) count = 16;
        rx_hold_left = 60;
        hold_done    = 1'b1;
      end

      send_random(count);
      random_done += count;
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mapper.pending() != 0)
      mapper.flag($sformatf("%0d destinations never came out", mapper.pending()));
    if (mapper.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
